// ===== src/dtg_pkg.sv =====
// ----------------------------------------------------------------------------
// dtg_pkg
// Shared types and constants for the debounced tap gesture detector.
// ----------------------------------------------------------------------------
package dtg_pkg;

    // field widths
    localparam int TIME_W     = 32;
    localparam int GAP_W      = 16;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 40;   // pin_level + event_time, padded to bytes
    localparam int M_TDATA_W  = 8;    // gesture, padded to a byte

    // reset values of the gap registers
    localparam logic [GAP_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [GAP_W-1:0] DOUBLE_RST   = 16'd300;
    localparam logic [GAP_W-1:0] SINGLE_RST   = 16'd1000;

    localparam logic [COUNT_W-1:0] TAP_COUNT_MAX = 8'd255;

    // register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_GAP = 2'd2;

    // gesture codes
    localparam logic GESTURE_SINGLE = 1'b0;
    localparam logic GESTURE_DOUBLE = 1'b1;

    // live register values
    typedef struct packed {
        logic [GAP_W-1:0] bounce_limit;
        logic [GAP_W-1:0] pair_window;
        logic [GAP_W-1:0] stale_window;
    } t_cfg;

    // one classified result leaving the core
    typedef struct packed {
        logic valid;
        logic gesture;
    } t_result;

endpackage

// ===== src/dtg_cfg.sv =====
// ----------------------------------------------------------------------------
// dtg_cfg
// Write-only register file for the debounce and tap gap settings.
// ----------------------------------------------------------------------------
module dtg_cfg import dtg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [GAP_W-1:0]     i_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bounce_limit <= DEBOUNCE_RST;
            r_cfg.pair_window  <= DOUBLE_RST;
            r_cfg.stale_window <= SINGLE_RST;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_DEBOUNCE:   r_cfg.bounce_limit <= i_wdata;
                CFG_DOUBLE_GAP: r_cfg.pair_window  <= i_wdata;
                CFG_SINGLE_GAP: r_cfg.stale_window <= i_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/dtg_core.sv =====
// ----------------------------------------------------------------------------
// dtg_core
// Input register, debounce filter, tap state and gesture classification.
// ----------------------------------------------------------------------------
module dtg_core import dtg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    // event transfer in
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_level,
    input  logic [TIME_W-1:0] i_time,
    // result toward the output register
    input  logic              i_res_ready,
    output logic              o_fire,
    output t_result           o_res
);

    logic               r_in_valid;
    logic               r_in_level;
    logic [TIME_W-1:0]  r_in_time;

    logic [TIME_W-1:0]  r_last_time;
    logic [COUNT_W-1:0] r_tap_count;
    logic [TIME_W-1:0]  r_first_time;
    logic               r_waiting;

    logic [TIME_W-1:0]  n_last_time;
    logic [COUNT_W-1:0] n_tap_count;
    logic [TIME_W-1:0]  n_first_time;
    logic               n_waiting;

    logic [TIME_W-1:0]  since_last;
    logic [TIME_W-1:0]  since_first;
    logic               accepted;
    logic               within_double;
    logic               past_single;
    logic               fire;
    t_result            res;

    // the held event moves on once the output side has room
    assign fire    = r_in_valid && i_res_ready;
    assign o_ready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_level <= i_level;
            r_in_time  <= i_time;
        end
    end

    // wrapping time differences
    assign since_last    = r_in_time - r_last_time;
    assign since_first   = r_in_time - r_first_time;
    assign accepted      = since_last > {{(TIME_W-GAP_W){1'b0}}, i_cfg.bounce_limit};
    assign within_double = since_first <= {{(TIME_W-GAP_W){1'b0}}, i_cfg.pair_window};
    assign past_single   = since_first > {{(TIME_W-GAP_W){1'b0}}, i_cfg.stale_window};

    // next tap state and result
    always_comb begin
        n_last_time  = r_last_time;
        n_tap_count  = r_tap_count;
        n_first_time = r_first_time;
        n_waiting    = r_waiting;
        res.valid    = 1'b0;
        res.gesture  = GESTURE_SINGLE;
        if (accepted) begin
            n_last_time = r_in_time;
            if (r_in_level) begin
                if (r_tap_count == '0) begin
                    n_first_time = r_in_time;
                end
                if (r_tap_count < TAP_COUNT_MAX) begin
                    n_tap_count = r_tap_count + COUNT_W'(1);
                end
                n_waiting = 1'b1;
            end else if (r_waiting) begin
                priority if (r_tap_count == 8'd1 && !within_double) begin
                    res.valid   = 1'b1;
                    res.gesture = GESTURE_SINGLE;
                end else if (r_tap_count == 8'd2 && within_double) begin
                    res.valid   = 1'b1;
                    res.gesture = GESTURE_DOUBLE;
                end else if (past_single) begin
                    res.valid = 1'b0;
                end else begin
                    res.valid = 1'b0;
                end
                // a reported gesture or a stale group clears the taps
                if (res.valid || past_single) begin
                    n_tap_count  = '0;
                    n_first_time = '0;
                    n_waiting    = 1'b0;
                end
            end
        end
    end

    // tap state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= '0;
            r_tap_count  <= '0;
            r_first_time <= '0;
            r_waiting    <= 1'b0;
        end else if (fire) begin
            r_last_time  <= n_last_time;
            r_tap_count  <= n_tap_count;
            r_first_time <= n_first_time;
            r_waiting    <= n_waiting;
        end
    end

    assign o_fire = fire;
    assign o_res  = res;

    // a pending group always holds at least one tap
    a_wait_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting == (r_tap_count != '0))
        else $error("tap count and pending flag disagree");

    // a double tap is only reported from a group of two
    a_double_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid && res.gesture == GESTURE_DOUBLE |-> r_tap_count == 8'd2)
        else $error("double tap reported without two taps");

    // a reported gesture leaves no taps behind
    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && res.valid |=> r_tap_count == '0 && !r_waiting)
        else $error("tap state not cleared after a gesture");

endmodule

// ===== src/dtg_out_reg.sv =====
// ----------------------------------------------------------------------------
// dtg_out_reg
// Result register that holds a gesture until the downstream transfer.
// ----------------------------------------------------------------------------
module dtg_out_reg import dtg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  t_result              i_res,
    output logic                 o_res_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [M_TDATA_W-1:0] o_data
);

    logic r_valid;
    logic r_gesture;

    assign o_res_ready = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_fire && i_res.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_fire && i_res.valid) begin
            r_gesture <= i_res.gesture;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {{(M_TDATA_W-1){1'b0}}, r_gesture};

endmodule

// ===== src/debounced_tap_gesture_detector_unit.sv =====
// ----------------------------------------------------------------------------
// debounced_tap_gesture_detector_unit
// Debounces touch edge events and classifies them into single and double taps.
//
//   channel   direction  signals                      contents
//   s         in         i_s_tvalid/o_s_tready/tdata  edge event
//   m         out        o_m_tvalid/i_m_tready/tdata  gesture
//   cfg       in         i_cfg_we/idx/wdata           gap registers
//
// One event a cycle is accepted while the result register has room; each event is
// held in the input register and its gesture then moves into the result register.
// The tap state updates once per event in the classify stage, from two wrapping
// subtracts and three compares.
// Reset is synchronous and active low; gap registers return to 50/300/1000.
// A waiting gesture stalls the input register only when m is not ready.
// ----------------------------------------------------------------------------
module debounced_tap_gesture_detector_unit import dtg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // event in
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [0] pin_level, [32:1] event_time
    // gesture out
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // [0] gesture
    // register writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GAP_W-1:0]     i_cfg_wdata
);

    t_cfg    cfg;
    t_result res;
    logic    fire;
    logic    res_ready;

    // configuration registers
    dtg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    // debounce and classification
    dtg_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_level     (i_s_tdata[0]),
        .i_time      (i_s_tdata[TIME_W:1]),
        .i_res_ready (res_ready),
        .o_fire      (fire),
        .o_res       (res)
    );

    // result register
    dtg_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata)
    );

endmodule
